// ===== design/spi_mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI master bit engine package
// Shared constants and codes for the tick-paced SPI mode 0 master.
// ----------------------------------------------------------------------------
package spi_mbe_pkg;

   // Byte slots in each store (a power of two, so the pointer wraps by itself)
   localparam int DEPTH    = 16;
   localparam int PTR_W    = $clog2(DEPTH);
   // Bits per byte on the wire
   localparam int BITS     = 8;
   localparam int BCNT_W   = $clog2(BITS + 1);
   localparam int BPOS_W   = (BITS > 1) ? $clog2(BITS) : 1;
   localparam int BYTE_W   = 8;

   // Register widths
   localparam int CNT_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   // Stream payload widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   // Operation codes carried in req_tuser
   typedef enum logic [REQ_TUSER_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_BYTE_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB_BIT_FIRST   = 2'd2;

   // Register reset values
   localparam logic [CNT_W-1:0] BYTE_COUNT_RST = 5'd16;

   // One captured request
   typedef struct packed {
      op_type             op;
      logic [PTR_W-1:0]   index;
      logic [BYTE_W-1:0]  data;
      logic               miso;
   } req_type;

   // One result item
   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic               busy_res;
      logic               cs_n;
      logic               mosi;
      logic               sclk;
   } rsp_type;

endpackage

// ===== design/spi_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// SPI master bit engine
// Tick-paced SPI mode 0 master with transmit and receive byte stores.
// ----------------------------------------------------------------------------
//  channel | direction | transfer when          | payload
//  req     | in        | req_tvalid&req_tready | tuser op, tdata index/data/miso
//  rsp     | out       | rsp_tvalid&rsp_tready | tdata pin levels, busy, read byte
//  csr     | in        | csr_valid&csr_ready   | csr_index, csr_data
//
//  One item per clock while rsp is not stalled; a taken request passes through
//  the input register, then the state update into the result register, before
//  its result is valid on rsp.
//  Synchronous active-high reset clears control state and the receive store;
//  the transmit store holds garbage until written.
//  A stalled rsp holds the pipe; req still takes an item while the input
//  register is free. csr is always ready.
// ----------------------------------------------------------------------------
module spi_master_bit_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   // op [1:0]
   input  logic [spi_mbe_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // index [3:0], data [11:4], miso [12], zero [15:13]
   input  logic [spi_mbe_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sclk [0], mosi [1], cs_n [2], busy_res [3], read_data [11:4], zero [15:12]
   output logic [spi_mbe_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [spi_mbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spi_mbe_pkg::CSR_DAT_W-1:0]     csr_data
);
   import spi_mbe_pkg::*;

   // Input stage
   req_type                 req_ff;
   logic                    req_valid_ff;
   logic                    advance;

   // Output stage
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;

   // Registers
   logic [CNT_W-1:0]        byte_count_ff;
   logic                    last_first_ff;
   logic                    msb_first_ff;

   // Engine state
   logic [BYTE_W-1:0]       tx_mem_ff [DEPTH];
   logic [BYTE_W-1:0]       rx_mem_ff [DEPTH];
   logic [BCNT_W-1:0]       bit_cnt_ff,  bit_cnt_in;
   logic [PTR_W-1:0]        ptr_ff,      ptr_in;
   logic                    active_ff,   active_in;
   logic                    clock_ff,    clock_in;
   logic                    mosi_ff,     mosi_in;
   logic                    select_ff,   select_in;

   // Derived values
   logic [PTR_W-1:0]        last_idx;
   logic [PTR_W-1:0]        end_slot;
   logic [BPOS_W-1:0]       bit_pos;
   logic                    clock_tgl;
   logic                    rx_we;

   // Handshakes
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         req_ff.op    <= op_type'(req_tuser);
         req_ff.index <= req_tdata[PTR_W-1:0];
         req_ff.data  <= req_tdata[PTR_W +: BYTE_W];
         req_ff.miso  <= req_tdata[PTR_W + BYTE_W];
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= BYTE_COUNT_RST;
         last_first_ff <= 1'b0;
         msb_first_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BYTE_COUNT:      byte_count_ff <= csr_data[CNT_W-1:0];
            CSR_LAST_BYTE_FIRST: last_first_ff <= csr_data[0];
            CSR_MSB_BIT_FIRST:   msb_first_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Index of the last byte slot, with the count clamped to 1..DEPTH
   always_comb begin
      if (byte_count_ff == '0) begin
         last_idx = '0;
      end else if (byte_count_ff > CNT_W'(DEPTH)) begin
         last_idx = PTR_W'(DEPTH - 1);
      end else begin
         last_idx = PTR_W'(byte_count_ff - CNT_W'(1));
      end
   end

   assign end_slot  = last_first_ff ? '0 : last_idx;
   assign bit_pos   = msb_first_ff ? (BPOS_W'(BITS - 1) - bit_cnt_ff[BPOS_W-1:0])
                                   : bit_cnt_ff[BPOS_W-1:0];
   assign clock_tgl = (bit_cnt_ff != '0) ? !clock_ff : clock_ff;

   // Next engine state for the item in the input register
   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      ptr_in     = ptr_ff;
      active_in  = active_ff;
      clock_in   = clock_ff;
      mosi_in    = mosi_ff;
      select_in  = select_ff;
      rx_we      = 1'b0;
      case (req_ff.op)
         OP_TICK: begin
            if (active_ff) begin
               clock_in = clock_tgl;
               if (!clock_tgl) begin
                  if (bit_cnt_ff >= BCNT_W'(BITS)) begin
                     // end of byte: idle MOSI high, step to the next slot
                     mosi_in    = 1'b1;
                     bit_cnt_in = '0;
                     if (ptr_ff == end_slot) begin
                        select_in = 1'b1;
                        active_in = 1'b0;
                     end
                     ptr_in = last_first_ff ? ptr_ff - PTR_W'(1) : ptr_ff + PTR_W'(1);
                  end else begin
                     // drive the next bit and store the sampled one
                     select_in  = 1'b0;
                     mosi_in    = tx_mem_ff[ptr_ff][bit_pos];
                     rx_we      = 1'b1;
                     bit_cnt_in = bit_cnt_ff + BCNT_W'(1);
                  end
               end
            end
         end
         OP_START: begin
            if (!active_ff) begin
               ptr_in    = last_first_ff ? last_idx : '0;
               active_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Form the result from the updated state
   always_comb begin
      rsp_in.sclk      = clock_in;
      rsp_in.mosi      = mosi_in;
      rsp_in.cs_n      = select_in;
      rsp_in.busy_res  = active_in;
      rsp_in.read_data = (req_ff.op == OP_READ) ? rx_mem_ff[req_ff.index] : '0;
   end

   // Engine state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff   <= '0;
         ptr_ff       <= '0;
         active_ff    <= 1'b0;
         clock_ff     <= 1'b0;
         mosi_ff      <= 1'b1;
         select_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            bit_cnt_ff   <= bit_cnt_in;
            ptr_ff       <= ptr_in;
            active_ff    <= active_in;
            clock_ff     <= clock_in;
            mosi_ff      <= mosi_in;
            select_ff    <= select_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Receive store: clear on reset, write one bit per driven bit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            rx_mem_ff[i] <= '0;
         end
      end else if (advance && rx_we) begin
         rx_mem_ff[ptr_ff][bit_pos] <= req_ff.miso;
      end
   end

   // Transmit store: written by write items only
   always_ff @(posedge clock) begin
      if (advance && (req_ff.op == OP_WRITE)) begin
         tx_mem_ff[req_ff.index] <= req_ff.data;
      end
   end

`ifndef ASSERT_OFF
   // Chip select is released whenever no transfer runs
   a_idle_deselect: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> select_ff)
      else $error("chip select low while idle");

   // The serial clock only rises inside a transfer
   a_clock_busy: assert property (@(posedge clock) disable iff (reset)
      clock_ff |-> active_ff)
      else $error("serial clock high while idle");

   // The serial clock is high only after a byte has begun
   a_clock_bits: assert property (@(posedge clock) disable iff (reset)
      clock_ff |-> (bit_cnt_ff != '0))
      else $error("serial clock high before first bit");

   // Bit counter never passes the byte length
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= BCNT_W'(BITS))
      else $error("bit counter out of range");

   // An item waiting in the input register moves once the result slot frees up
   a_no_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("request not processed with result slot free");
`endif

endmodule
